// ===== hw/rtl/lsbm_pkg.sv =====
// Package: shared constants, types and helpers for the LED stimulus blink manager.
package lsbm_pkg;

  localparam int NUM_LEDS    = 4;
  localparam int LED_W       = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int ASSIGN_REGS = 4;

  localparam int STIM_W     = 7;
  localparam int ACT_W      = 2;
  localparam int ASSIGN_W   = 8;
  localparam int INV_BIT    = 7;
  localparam int PERIOD_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_IDX_W  = 2;
  localparam int OUT_ST_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd4;
  localparam logic [PERIOD_W-1:0]  PERIOD_RESET = 16'd750;

  localparam logic MODE_PUBLISH = 1'b0;
  localparam logic MODE_TICK    = 1'b1;

  localparam logic [ACT_W-1:0] ACT_OFF     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ON      = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ONESHOT = 2'd2;
  localparam logic [ACT_W-1:0] ACT_BAD     = 2'd3;

  typedef struct packed {
    logic                  en;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Command passed from front to back
  typedef struct packed {
    logic              is_tick;
    logic              parity;
    logic [STIM_W-1:0] stim;
    logic [ACT_W-1:0]  act;
  } cmd_t;

  function automatic logic [OUT_IDX_W-1:0] led_idx_out(input logic [LED_W-1:0] idx);
    logic [LED_W+OUT_IDX_W-1:0] t;
    t = {{OUT_IDX_W{1'b0}}, idx};
    return t[OUT_IDX_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/lsbm_if.sv =====
// Interfaces: input item channel and result channel.
interface lsbm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [lsbm_pkg::STIM_W-1:0] stimulus_id;
  logic [lsbm_pkg::ACT_W-1:0]  action;

  modport source (output valid, output mode, output stimulus_id, output action, input ready);
  modport sink   (input valid, input mode, input stimulus_id, input action, output ready);
endinterface

interface lsbm_out_if;
  logic                          valid;
  logic                          ready;
  logic [lsbm_pkg::OUT_IDX_W-1:0] led_index;
  logic [lsbm_pkg::OUT_ST_W-1:0]  led_state;
  logic                          last;

  modport source (output valid, output led_index, output led_state, output last, input ready);
  modport sink   (input valid, input led_index, input led_state, input last, output ready);
endinterface

// ===== hw/rtl/lsbm_front.sv =====
// Front end: accepts items, runs the blink timer, drops no-op items, queues commands.
module lsbm_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_mode,
  input  logic [lsbm_pkg::STIM_W-1:0] in_stim,
  input  logic [lsbm_pkg::ACT_W-1:0]  in_act,
  input  lsbm_pkg::cfg_wr_t         cfg,
  output logic                      push_valid,
  input  logic                      push_ready,
  output lsbm_pkg::cmd_t            push_cmd
);
  import lsbm_pkg::*;

  logic [PERIOD_W-1:0] period_r;
  logic [PERIOD_W-1:0] ms_r, ms_nxt;
  logic                started_r, started_nxt;
  logic                parity_r, parity_nxt;
  logic [PERIOD_W:0]   elapsed;
  logic [PERIOD_W-1:0] elapsed_sat;
  logic                step;
  logic                accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  assign elapsed     = {1'b0, ms_r} + {{PERIOD_W{1'b0}}, 1'b1};
  assign elapsed_sat = elapsed[PERIOD_W] ? {PERIOD_W{1'b1}} : elapsed[PERIOD_W-1:0];
  assign step        = !started_r || (elapsed_sat >= period_r);

  always_comb begin
    ms_nxt      = ms_r;
    started_nxt = started_r;
    parity_nxt  = parity_r;
    if (accept && in_mode == MODE_TICK) begin
      if (step) begin
        ms_nxt      = '0;
        started_nxt = 1'b1;
        parity_nxt  = !parity_r;
      end else begin
        ms_nxt = elapsed_sat;
      end
    end
  end

  always_comb begin
    push_valid = 1'b0;
    if (in_valid) begin
      if (in_mode == MODE_TICK) push_valid = step;
      else                      push_valid = (in_act != ACT_BAD);
    end
    push_cmd.is_tick = (in_mode == MODE_TICK);
    push_cmd.parity  = parity_nxt;
    push_cmd.stim    = in_stim;
    push_cmd.act     = in_act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= PERIOD_RESET;
      ms_r      <= '0;
      started_r <= 1'b0;
      parity_r  <= 1'b0;
    end else begin
      if (cfg.en && cfg.index == REG_PERIOD) period_r <= cfg.data[PERIOD_W-1:0];
      ms_r      <= ms_nxt;
      started_r <= started_nxt;
      parity_r  <= parity_nxt;
    end
  end

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> ms_r == '0)
    else $error("blink counter moved before first step");

endmodule

// ===== hw/rtl/lsbm_queue.sv =====
// Two-entry command queue between front and back.
module lsbm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  lsbm_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lsbm_pkg::cmd_t pop_cmd
);
  import lsbm_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 2'd1;
    else if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

endmodule

// ===== hw/rtl/lsbm_back.sv =====
// Back end: applies a command to all LEDs, then reports changed LEDs one per cycle while the output is not stalled.
module lsbm_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lsbm_pkg::cfg_wr_t                cfg,
  input  logic                             pop_valid,
  output logic                             pop_ready,
  input  lsbm_pkg::cmd_t                   pop_cmd,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lsbm_pkg::OUT_IDX_W-1:0]   out_led_index,
  output logic [lsbm_pkg::OUT_ST_W-1:0]    out_led_state,
  output logic                             out_last
);
  import lsbm_pkg::*;

  logic [ASSIGN_W-1:0] assign_r [NUM_LEDS];
  logic [ACT_W-1:0]    drive_r  [NUM_LEDS];
  logic [ACT_W-1:0]    pend_r   [NUM_LEDS];
  logic [ACT_W-1:0]    drive_nxt [NUM_LEDS];
  logic [ACT_W-1:0]    pend_nxt  [NUM_LEDS];
  logic [NUM_LEDS-1:0] chg;
  logic [NUM_LEDS-1:0] mask_r, mask_nxt;
  logic [LED_W-1:0]    sel;
  logic                pop, emit_go, last_nxt;

  logic                 out_valid_r;
  logic [LED_W-1:0]     out_idx_r;
  logic [ACT_W-1:0]     out_state_r;
  logic                 out_last_r;

  assign pop_ready = (mask_r == '0);
  assign pop       = pop_valid && pop_ready;
  assign emit_go   = (mask_r != '0) && (!out_valid_r || out_ready);

  // Per-LED update for the command at the head of the queue
  always_comb begin
    logic [ACT_W-1:0] d;
    d = ACT_OFF;
    for (int i = 0; i < NUM_LEDS; i++) begin
      drive_nxt[i] = drive_r[i];
      pend_nxt[i]  = pend_r[i];
      chg[i]       = 1'b0;
      if (!pop_cmd.is_tick) begin
        if (assign_r[i][STIM_W-1:0] == pop_cmd.stim) begin
          pend_nxt[i] = pop_cmd.act;
          if (pop_cmd.act != ACT_ONESHOT) begin
            d = {1'b0, pop_cmd.act[0] ^ assign_r[i][INV_BIT]};
            if (d != drive_r[i]) begin
              drive_nxt[i] = d;
              chg[i]       = 1'b1;
            end
          end
        end
      end else if (pop_cmd.parity) begin
        // odd step: pending one-shot lights, reported even if already lit
        if (pend_r[i] == ACT_ONESHOT) begin
          drive_nxt[i] = ACT_ONESHOT;
          pend_nxt[i]  = ACT_OFF;
          chg[i]       = 1'b1;
        end
      end else if (drive_r[i] == ACT_ONESHOT) begin
        drive_nxt[i] = ACT_OFF;
        chg[i]       = 1'b1;
      end
    end
  end

  // Lowest pending LED goes out first
  always_comb begin
    sel = '0;
    for (int i = NUM_LEDS - 1; i >= 0; i--) begin
      if (mask_r[i]) sel = LED_W'(i);
    end
    mask_nxt = mask_r;
    mask_nxt[sel] = 1'b0;
    last_nxt = (mask_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        assign_r[i] <= '0;
        drive_r[i]  <= ACT_OFF;
        pend_r[i]   <= ACT_OFF;
      end
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_LEDS && i < ASSIGN_REGS; i++) begin
        if (cfg.en && cfg.index == CFG_IDX_W'(i)) assign_r[i] <= cfg.data[ASSIGN_W-1:0];
      end
      if (pop) begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          drive_r[i] <= drive_nxt[i];
          pend_r[i]  <= pend_nxt[i];
        end
        mask_r <= chg;
      end else if (emit_go) begin
        mask_r <= mask_nxt;
      end
      if (emit_go)        out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_idx_r   <= sel;
      out_state_r <= drive_r[sel];
      out_last_r  <= last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_index = led_idx_out(out_idx_r);
  assign out_led_state = out_state_r;
  assign out_last      = out_last_r;

  for (genvar g = 0; g < NUM_LEDS; g++) begin : g_chk
    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
      drive_r[g] != ACT_BAD && pend_r[g] != ACT_BAD)
      else $error("LED state holds undefined code");
  end

  a_more_after: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && !last_nxt |=> mask_r != '0 && out_valid_r && !out_last_r)
    else $error("item ended before its last result");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && last_nxt |=> mask_r == '0 || $past(pop))
    else $error("results left after last");

endmodule

// ===== hw/rtl/led_stimulus_blink_manager.sv =====
// Top level: LED stimulus blink manager, front end, command queue and back end.
// An item's first result passes through the queue entry, the back-end change mask and the output register.
// Throughput: the front takes one item per cycle while the 2-entry queue has room; the
//   back takes a new command only after reporting every changed LED (up to NUM_LEDS) of the last.
// Idle ticks and undefined actions cause no result and finish in the front.
// Reset (rst_n low, synchronous) clears all LED, timer and queue state; period is 750.
module led_stimulus_blink_manager (
  input  logic                              clk,
  input  logic                              rst_n,
  lsbm_in_if.sink                           in_ch,
  lsbm_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [lsbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsbm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lsbm_pkg::*;

  cfg_wr_t cfg;
  logic    push_valid, push_ready, pop_valid, pop_ready;
  cmd_t    push_cmd, pop_cmd;

  assign cfg.en    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  lsbm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_mode    (in_ch.mode),
    .in_stim    (in_ch.stimulus_id),
    .in_act     (in_ch.action),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  lsbm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  lsbm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_cmd       (pop_cmd),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_led_index (out_ch.led_index),
    .out_led_state (out_ch.led_state),
    .out_last      (out_ch.last)
  );

endmodule
